@@ src/rrc4_pkg.sv @@
// shared types and constants for the reduced rc4 stream cipher
`default_nettype none

package rrc4_pkg;

  // payload and key geometry
  localparam int DATA_W    = 8;
  localparam int KEY_BYTES = 30;
  localparam int KSEL_W    = 5;
  localparam int ADDR_W    = 5;
  localparam int PDATA_W   = 64;
  localparam int TOP_W     = 48;

  // whole key, byte 0 in the low bits
  typedef logic [KEY_BYTES-1:0][7:0] key_t;

  // configuration register indexes (paddr bits 4:3)
  typedef enum logic [1:0] {
    REG_KEY_LO   = 2'd0,
    REG_KEY_MID  = 2'd1,
    REG_KEY_HIGH = 2'd2,
    REG_KEY_TOP  = 2'd3
  } reg_idx_t;

  // input transaction payload
  typedef struct packed {
    logic [DATA_W-1:0] data_byte;
    logic              last_in_buffer;
  } item_t;

  // output transaction payload
  typedef struct packed {
    logic [DATA_W-1:0] out_byte;
    logic              last_out;
  } result_t;

endpackage

`default_nettype wire

@@ src/reduced_rc4_stream_cipher.sv @@
// top level: key registers on the apb port and the cipher core
// a byte is accepted only while the core is idle, so each byte finishes before the next;
//   the first byte of a buffer first runs the key schedule (an identity fill of the
//   table, then keyed swaps, then a restart of the data step)
// data step: the table memory has one write and one registered read port, so a byte
//   is done in steps (read S[i], read S[j], swap write with read S[t], final write)
// reset: synchronous; clears the key registers and marks a schedule pending
`default_nettype none

module reduced_rc4_stream_cipher #(
  parameter int TABLE_SIZE = 128,
  parameter int KEY_LENGTH = 30
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          item_valid,
  output logic                               item_ready,
  input  wire rrc4_pkg::item_t               item,
  output logic                               result_valid,
  input  wire logic                          result_ready,
  output rrc4_pkg::result_t                  result,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [rrc4_pkg::ADDR_W-1:0]   paddr,
  input  wire logic [rrc4_pkg::PDATA_W-1:0]  pwdata,
  output logic [rrc4_pkg::PDATA_W-1:0]       prdata,
  output logic                               pready
);
  import rrc4_pkg::*;

  logic [PDATA_W-1:0] key_lo, key_mid, key_high;
  logic [TOP_W-1:0]   key_top;
  key_t               key;
  reg_idx_t           reg_idx;
  logic               wr_stb;

  assign pready  = 1'b1;
  assign reg_idx = reg_idx_t'(paddr[4:3]);
  assign wr_stb  = psel && penable && pwrite && pready;
  assign key     = {key_top, key_high, key_mid, key_lo};

  // key register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      key_lo   <= '0;
      key_mid  <= '0;
      key_high <= '0;
      key_top  <= '0;
    end else if (wr_stb) begin
      unique case (reg_idx)
        REG_KEY_LO:   key_lo   <= pwdata;
        REG_KEY_MID:  key_mid  <= pwdata;
        REG_KEY_HIGH: key_high <= pwdata;
        REG_KEY_TOP:  key_top  <= pwdata[TOP_W-1:0];
      endcase
    end
  end

  // register read back
  always_comb begin
    unique case (reg_idx)
      REG_KEY_LO:   prdata = key_lo;
      REG_KEY_MID:  prdata = key_mid;
      REG_KEY_HIGH: prdata = key_high;
      REG_KEY_TOP:  prdata = PDATA_W'(key_top);
    endcase
  end

  // cipher core
  rrc4_core #(
    .TABLE_SIZE (TABLE_SIZE),
    .KEY_LENGTH (KEY_LENGTH)
  ) u_core (
    .clk          (clk),
    .rst          (rst),
    .key          (key),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

endmodule

`default_nettype wire

@@ src/rrc4_core.sv @@
// permutation table memory, key schedule and keystream sequencer
`default_nettype none

module rrc4_core #(
  parameter int TABLE_SIZE = 128,
  parameter int KEY_LENGTH = 30
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire rrc4_pkg::key_t    key,
  input  wire logic              item_valid,
  output logic                   item_ready,
  input  wire rrc4_pkg::item_t   item,
  output logic                   result_valid,
  input  wire logic              result_ready,
  output rrc4_pkg::result_t      result
);
  import rrc4_pkg::*;

  localparam int IDX_W  = $clog2(TABLE_SIZE);
  localparam int KIDX_W = (KEY_LENGTH > 1) ? $clog2(KEY_LENGTH) : 1;
  localparam logic [IDX_W-1:0]  IDX_LAST  = IDX_W'(TABLE_SIZE - 1);
  localparam logic [KIDX_W-1:0] KIDX_LAST = KIDX_W'(KEY_LENGTH - 1);
  localparam logic [IDX_W:0]    TS1       = (IDX_W + 1)'(TABLE_SIZE);
  localparam logic [IDX_W+1:0]  TS2       = (IDX_W + 2)'(TABLE_SIZE);
  localparam logic [IDX_W+1:0]  TS2X2     = (IDX_W + 2)'(2 * TABLE_SIZE);

  typedef enum logic [9:0] {
    ST_IDLE    = 10'b00_0000_0001,
    ST_FILL    = 10'b00_0000_0010,
    ST_KS_RD_N = 10'b00_0000_0100,
    ST_KS_RD_J = 10'b00_0000_1000,
    ST_KS_WR_N = 10'b00_0001_0000,
    ST_KS_WR_J = 10'b00_0010_0000,
    ST_RD_I    = 10'b00_0100_0000,
    ST_RD_J    = 10'b00_1000_0000,
    ST_SWAP    = 10'b01_0000_0000,
    ST_FIN     = 10'b10_0000_0000
  } state_t;

  state_t state, state_next;

  // control and working registers
  logic              pending, pending_next;
  logic [IDX_W-1:0]  idx_i, idx_i_next;
  logic [IDX_W-1:0]  idx_j, idx_j_next;
  logic [IDX_W-1:0]  cnt, cnt_next;
  logic [KIDX_W-1:0] kidx, kidx_next;
  logic [IDX_W-1:0]  s_held, s_held_next;
  logic              fwd_hit, fwd_hit_next;
  logic [IDX_W-1:0]  fwd_val, fwd_val_next;
  logic [DATA_W-1:0] data_q, data_q_next;
  logic              last_q, last_q_next;
  logic              result_valid_next;
  result_t           result_next;

  // table memory ports
  logic [IDX_W-1:0]  mem [TABLE_SIZE];
  logic [IDX_W-1:0]  rdata;
  logic              rd_en, wr_en;
  logic [IDX_W-1:0]  rd_addr, wr_addr, wr_data;

  // key byte reduced modulo the table size
  logic [IDX_W-1:0]  key_mod [256];
  for (genvar g = 0; g < 256; g++) begin : g_kmod
    assign key_mod[g] = IDX_W'(g % TABLE_SIZE);
  end

  // index arithmetic
  logic [IDX_W-1:0]  i_inc, cnt_inc, ks_j, dj, t_idx, ks;
  logic [KIDX_W-1:0] kidx_inc;
  logic [7:0]        kb;
  logic [IDX_W+1:0]  sum3;
  logic [IDX_W:0]    sum_dj, sum_t;

  assign i_inc    = (idx_i == IDX_LAST) ? '0 : idx_i + 1'b1;
  assign cnt_inc  = (cnt == IDX_LAST) ? '0 : cnt + 1'b1;
  assign kidx_inc = (kidx == KIDX_LAST) ? '0 : kidx + 1'b1;
  assign kb       = key[KSEL_W'(kidx)];

  // schedule step: j + S[n] + key, below three table sizes
  assign sum3 = (IDX_W + 2)'(idx_j) + (IDX_W + 2)'(rdata) + (IDX_W + 2)'(key_mod[kb]);
  always_comb begin
    priority if (sum3 >= TS2X2) begin
      ks_j = IDX_W'(sum3 - TS2X2);
    end else if (sum3 >= TS2) begin
      ks_j = IDX_W'(sum3 - TS2);
    end else begin
      ks_j = IDX_W'(sum3);
    end
  end

  // data step: j + S[i] and S[i] + S[j]
  assign sum_dj = {1'b0, idx_j} + {1'b0, rdata};
  assign dj     = (sum_dj >= TS1) ? IDX_W'(sum_dj - TS1) : IDX_W'(sum_dj);
  assign sum_t  = {1'b0, s_held} + {1'b0, rdata};
  assign t_idx  = (sum_t >= TS1) ? IDX_W'(sum_t - TS1) : IDX_W'(sum_t);

  // keystream value with forwarding of the swap writes
  assign ks = fwd_hit ? fwd_val : rdata;

  assign item_ready = (state == ST_IDLE);

  // sequencer
  always_comb begin
    state_next        = state;
    pending_next      = pending;
    idx_i_next        = idx_i;
    idx_j_next        = idx_j;
    cnt_next          = cnt;
    kidx_next         = kidx;
    s_held_next       = s_held;
    fwd_hit_next      = fwd_hit;
    fwd_val_next      = fwd_val;
    data_q_next       = data_q;
    last_q_next       = last_q;
    result_next       = result;
    result_valid_next = result_valid && !result_ready;
    rd_en             = 1'b0;
    rd_addr           = i_inc;
    wr_en             = 1'b0;
    wr_addr           = cnt;
    wr_data           = cnt;
    unique case (state)
      ST_IDLE: begin
        if (item_valid) begin
          data_q_next = item.data_byte;
          last_q_next = item.last_in_buffer;
          if (pending) begin
            cnt_next   = '0;
            state_next = ST_FILL;
          end else begin
            idx_i_next = i_inc;
            rd_en      = 1'b1;
            rd_addr    = i_inc;
            state_next = ST_RD_J;
          end
        end
      end
      ST_FILL: begin
        wr_en   = 1'b1;
        wr_addr = cnt;
        wr_data = cnt;
        cnt_next = cnt_inc;
        if (cnt == IDX_LAST) begin
          idx_j_next = '0;
          kidx_next  = '0;
          state_next = ST_KS_RD_N;
        end
      end
      ST_KS_RD_N: begin
        rd_en      = 1'b1;
        rd_addr    = cnt;
        state_next = ST_KS_RD_J;
      end
      ST_KS_RD_J: begin
        s_held_next = rdata;
        idx_j_next  = ks_j;
        rd_en       = 1'b1;
        rd_addr     = ks_j;
        state_next  = ST_KS_WR_N;
      end
      ST_KS_WR_N: begin
        wr_en      = 1'b1;
        wr_addr    = cnt;
        wr_data    = rdata;
        state_next = ST_KS_WR_J;
      end
      ST_KS_WR_J: begin
        wr_en   = 1'b1;
        wr_addr = idx_j;
        wr_data = s_held;
        if (cnt == IDX_LAST) begin
          idx_i_next   = '0;
          idx_j_next   = '0;
          pending_next = 1'b0;
          state_next   = ST_RD_I;
        end else begin
          cnt_next   = cnt_inc;
          kidx_next  = kidx_inc;
          state_next = ST_KS_RD_N;
        end
      end
      ST_RD_I: begin
        idx_i_next = i_inc;
        rd_en      = 1'b1;
        rd_addr    = i_inc;
        state_next = ST_RD_J;
      end
      ST_RD_J: begin
        s_held_next = rdata;
        idx_j_next  = dj;
        rd_en       = 1'b1;
        rd_addr     = dj;
        state_next  = ST_SWAP;
      end
      ST_SWAP: begin
        // write S[i] <- S[j] and read S[t] in the same cycle
        wr_en   = 1'b1;
        wr_addr = idx_i;
        wr_data = rdata;
        rd_en   = 1'b1;
        rd_addr = t_idx;
        priority if (t_idx == idx_i) begin
          fwd_hit_next = 1'b1;
          fwd_val_next = rdata;
        end else if (t_idx == idx_j) begin
          fwd_hit_next = 1'b1;
          fwd_val_next = s_held;
        end else begin
          fwd_hit_next = 1'b0;
          fwd_val_next = rdata;
        end
        state_next = ST_FIN;
      end
      ST_FIN: begin
        // write S[j] <- S[i]; wait here while the output register is full
        wr_en   = 1'b1;
        wr_addr = idx_j;
        wr_data = s_held;
        if (!result_valid || result_ready) begin
          result_next.out_byte = data_q ^ DATA_W'(ks);
          result_next.last_out = last_q;
          result_valid_next    = 1'b1;
          pending_next         = last_q;
          state_next           = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // table memory, one write and one registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata <= mem[rd_addr];
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      pending      <= 1'b1;
      idx_i        <= '0;
      idx_j        <= '0;
      result_valid <= 1'b0;
    end else begin
      state        <= state_next;
      pending      <= pending_next;
      idx_i        <= idx_i_next;
      idx_j        <= idx_j_next;
      result_valid <= result_valid_next;
    end
  end

  // working and payload registers
  always_ff @(posedge clk) begin
    cnt     <= cnt_next;
    kidx    <= kidx_next;
    s_held  <= s_held_next;
    fwd_hit <= fwd_hit_next;
    fwd_val <= fwd_val_next;
    data_q  <= data_q_next;
    last_q  <= last_q_next;
    result  <= result_next;
  end

  // a transaction that opens a buffer starts the table fill
  a_fill_start: assert property (@(posedge clk) disable iff (rst)
    item_valid && item_ready && pending |=> state == ST_FILL)
    else $error("buffer start did not enter the table fill");

  // a result only appears from the final step of a byte
  a_result_src: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(state == ST_FIN))
    else $error("result raised outside the final step");

  // indices stay within the table
  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    (32'(idx_i) < TABLE_SIZE) && (32'(idx_j) < TABLE_SIZE))
    else $error("index beyond table size");

  // end of the key schedule clears both indices and the pending flag
  a_sched_end: assert property (@(posedge clk) disable iff (rst)
    state == ST_KS_WR_J && cnt == IDX_LAST |=> !pending && idx_i == '0 && idx_j == '0)
    else $error("key schedule did not finish cleanly");

endmodule

`default_nettype wire

@@ tb/tb_reduced_rc4_stream_cipher.sv @@
// self-checking testbench for the reduced rc4 stream cipher
module tb_reduced_rc4_stream_cipher;
  timeunit 1ns;
  timeprecision 1ps;

  import rrc4_pkg::*;

  localparam int          TBL_SIZE    = 128;
  localparam int          STALL_LIMIT = 5000;
  localparam int          LONG_HOLD   = 400;
  localparam logic [63:0] TOP_MASK    = (64'd1 << TOP_W) - 64'd1;

  logic                clk;
  logic                rst          = 1'b1;
  logic                item_valid   = 1'b0;
  logic                item_ready;
  item_t               item         = '0;
  logic                result_valid;
  logic                result_ready = 1'b0;
  result_t             result;
  logic                psel         = 1'b0;
  logic                penable      = 1'b0;
  logic                pwrite       = 1'b0;
  logic [ADDR_W-1:0]   paddr        = '0;
  logic [PDATA_W-1:0]  pwdata       = '0;
  logic [PDATA_W-1:0]  prdata;
  logic                pready;

  reduced_rc4_stream_cipher i_dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  // 100 MHz clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // cipher state as the testbench sees it
  logic [6:0]       perm_model [TBL_SIZE];
  logic [6:0]       ptr_i      = '0;
  logic [6:0]       ptr_j      = '0;
  logic             reschedule = 1'b1;
  logic [3:0][63:0] key_words  = '0;
  result_t          cipher_out_q [$];

  int      fail_count  = 0;
  int      burst_left  = 0;
  logic    hold_toggle = 1'b0;
  logic    hold_seen   = 1'b0;
  int      hold_left   = 0;
  int      recv_mode   = 0;
  int      mode_left   = 0;
  int      idle_count  = 0;
  result_t want;

  // key byte used at schedule step n, wrapping over the key length
  function automatic logic [7:0] key_byte_at(int n);
    int k;
    k = n % KEY_BYTES;
    return key_words[k / 8][(k % 8) * 8 +: 8];
  endfunction

  // identity fill then keyed swaps, indices cleared
  function automatic void run_key_schedule();
    int         j;
    logic [6:0] tmp;
    for (int n = 0; n < TBL_SIZE; n++) perm_model[n] = 7'(n);
    j = 0;
    for (int n = 0; n < TBL_SIZE; n++) begin
      j = (j + perm_model[n] + key_byte_at(n)) % TBL_SIZE;
      tmp           = perm_model[n];
      perm_model[n] = perm_model[j];
      perm_model[j] = tmp;
    end
    ptr_i = '0;
    ptr_j = '0;
  endfunction

  // encrypt one byte, keystream is 7 bits so bit 7 passes through
  function automatic result_t cipher_step(item_t it);
    result_t    r;
    logic [6:0] tmp;
    logic [6:0] ks_idx;
    if (reschedule) begin
      run_key_schedule();
      reschedule = 1'b0;
    end
    ptr_i             = ptr_i + 7'd1;
    ptr_j             = ptr_j + perm_model[ptr_i];
    tmp               = perm_model[ptr_i];
    perm_model[ptr_i] = perm_model[ptr_j];
    perm_model[ptr_j] = tmp;
    ks_idx            = perm_model[ptr_i] + perm_model[ptr_j];
    r.out_byte        = it.data_byte ^ {1'b0, perm_model[ks_idx]};
    r.last_out        = it.last_in_buffer;
    if (it.last_in_buffer) reschedule = 1'b1;
    return r;
  endfunction

  // offer one byte in bursts with random gaps, predict on acceptance
  task automatic send_byte(input logic [7:0] data, input logic last);
    item_t it;
    int    gap;
    it.data_byte      = data;
    it.last_in_buffer = last;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        item_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 80) : $urandom_range(1, 10);
    end
    burst_left--;
    item_valid <= 1'b1;
    item       <= it;
    do @(posedge clk); while (!item_ready);
    cipher_out_q.push_back(cipher_step(it));
  endtask

  // stop offering and wait for every outstanding result
  task automatic wait_drained();
    item_valid <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (cipher_out_q.size() != 0);
  endtask

  // apb writes to the selected key registers, block must be idle
  task automatic write_keys(input logic [3:0][63:0] vals, input logic [3:0] which);
    reg_idx_t idx;
    for (int r = 0; r < 4; r++) begin
      idx = reg_idx_t'(r);
      if (which[idx]) begin
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= vals[idx];
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        key_words[idx] = (idx == REG_KEY_TOP) ? (vals[idx] & TOP_MASK) : vals[idx];
      end
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  function automatic logic [3:0][63:0] random_key();
    logic [3:0][63:0] k;
    for (int r = 0; r < 4; r++) k[r] = {$urandom, $urandom};
    return k;
  endfunction

  // zero key and the extreme byte values
  task automatic test_extreme_bytes();
    write_keys('0, 4'hF);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'h7F, 1'b0);
    send_byte(8'h01, 1'b0);
    send_byte(8'hFE, 1'b1);
  endtask

  // every byte closes its buffer, so each one sees a fresh schedule
  task automatic test_byte_per_buffer();
    wait_drained();
    write_keys(random_key(), 4'hF);
    send_byte(8'h55, 1'b1);
    send_byte(8'hAA, 1'b1);
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b1);
  endtask

  // all-ones key, top register keeps only its low bits
  task automatic test_full_key();
    wait_drained();
    write_keys({4{64'hFFFF_FFFF_FFFF_FFFF}}, 4'hF);
    for (int n = 0; n < 5; n++) send_byte(8'($urandom_range(0, 255)), n == 4);
  endtask

  // new key written mid-buffer only applies from the next buffer
  task automatic test_key_change_mid_buffer();
    wait_drained();
    write_keys({4{64'hA5A5_5A5A_A5A5_5A5A}}, 4'hF);
    for (int n = 0; n < 3; n++) send_byte(8'($urandom_range(0, 255)), 1'b0);
    wait_drained();
    write_keys(random_key(), 4'hF);
    send_byte(8'($urandom_range(0, 255)), 1'b0);
    send_byte(8'($urandom_range(0, 255)), 1'b1);
    send_byte(8'($urandom_range(0, 255)), 1'b0);
    send_byte(8'($urandom_range(0, 255)), 1'b1);
  endtask

  // random buffers over several key settings
  task automatic test_random_buffers();
    int         sent;
    int         len;
    int         pick;
    logic       closed;
    logic [3:0] which;
    for (int phase = 0; phase < 4; phase++) begin
      wait_drained();
      which = (phase == 0) ? 4'hF : 4'($urandom_range(1, 15));
      write_keys(random_key(), which);
      sent = 0;
      while (sent < 90) begin
        pick = $urandom_range(0, 9);
        if (pick == 0)      len = 1;
        else if (pick == 1) len = $urandom_range(30, 60);
        else                len = $urandom_range(2, 12);
        // the final buffer of a phase may stay open across the key change
        closed = !((sent + len >= 90) && ($urandom_range(0, 1) == 1));
        for (int n = 0; n < len; n++)
          send_byte(8'($urandom_range(0, 255)), closed && (n == len - 1));
        sent += len;
      end
    end
  endtask

  // receiver holds off while bytes keep coming, the block must stall its input
  task automatic test_input_backpressure();
    hold_toggle <= ~hold_toggle;
    burst_left = 40;
    for (int n = 0; n < 40; n++) send_byte(8'($urandom_range(0, 255)), (n == 19) || (n == 39));
  endtask

  // result check and receiver stall pattern
  always @(posedge clk) begin
    if (rst) begin
      result_ready <= 1'b0;
      hold_seen    <= hold_toggle;
    end else begin
      if (result_valid && result_ready) begin
        if (cipher_out_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("unexpected result transaction: out_byte %h last_out %b",
                     result.out_byte, result.last_out);
        end else begin
          want = cipher_out_q.pop_front();
          if (result.out_byte !== want.out_byte) begin
            fail_count++;
            if (fail_count <= 10)
              $display("out_byte mismatch: expected %h, got %h", want.out_byte, result.out_byte);
          end
          if (result.last_out !== want.last_out) begin
            fail_count++;
            if (fail_count <= 10)
              $display("last_out mismatch: expected %b, got %b", want.last_out, result.last_out);
          end
        end
      end
      // long hold-off on request, otherwise a changing stall pattern
      if (hold_toggle != hold_seen) begin
        hold_seen    <= hold_toggle;
        hold_left    <= LONG_HOLD;
        result_ready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left    <= hold_left - 1;
        result_ready <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          recv_mode <= $urandom_range(0, 2);
          mode_left <= $urandom_range(20, 80);
        end else begin
          mode_left <= mode_left - 1;
        end
        case (recv_mode)
          0:       result_ready <= 1'b1;
          1:       result_ready <= 1'($urandom_range(0, 1));
          default: result_ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk) begin
    if (rst || (item_valid && item_ready) || (result_valid && result_ready)) begin
      idle_count <= 0;
    end else if (idle_count == STALL_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      idle_count <= idle_count + 1;
    end
  end

  // test sequence
  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    test_extreme_bytes();
    test_byte_per_buffer();
    test_full_key();
    test_key_change_mid_buffer();
    test_random_buffers();
    test_input_backpressure();
    wait_drained();
    repeat (20) @(posedge clk);
    if (fail_count == 0 && cipher_out_q.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

@@ reduced_rc4_stream_cipher.f @@
src/rrc4_pkg.sv
src/rrc4_core.sv
src/reduced_rc4_stream_cipher.sv
tb/tb_reduced_rc4_stream_cipher.sv
